// ===== sv/markup_tag_nesting_scanner_assert.svh =====
// Assertion helpers shared by the scanner RTL.
`ifndef MARKUP_TAG_NESTING_SCANNER_ASSERT_SVH
`define MARKUP_TAG_NESTING_SCANNER_ASSERT_SVH

// Checked on every edge outside reset.
`define MKTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define MKTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== sv/mkts_pkg.sv =====
`default_nettype none

package mkts_pkg;

  // Parse modes
  localparam logic [1:0] MODE_CONTENT    = 2'd0;
  localparam logic [1:0] MODE_TAG_OPENED = 2'd1;
  localparam logic [1:0] MODE_OPEN_TAG   = 2'd2;
  localparam logic [1:0] MODE_END_TAG    = 2'd3;

  // Quote modes
  localparam logic [1:0] QUOTE_NONE   = 2'd0;
  localparam logic [1:0] QUOTE_SINGLE = 2'd1;
  localparam logic [1:0] QUOTE_DOUBLE = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
  localparam logic [1:0] ERR_UNMATCHED = 2'd2;

  // Markup characters
  localparam logic [7:0] CH_LT     = 8'h3C;  // '<'
  localparam logic [7:0] CH_SLASH  = 8'h2F;  // '/'
  localparam logic [7:0] CH_QMARK  = 8'h3F;  // '?'
  localparam logic [7:0] CH_GT     = 8'h3E;  // '>'
  localparam logic [7:0] CH_DQUOTE = 8'h22;  // '"'
  localparam logic [7:0] CH_SQUOTE = 8'h27;  // single quote

  localparam int unsigned FieldOffW = 24;
  localparam int unsigned FieldDepW = 6;

  typedef struct packed {
    logic [1:0]           error_code;
    logic                 self_closing;
    logic [FieldOffW-1:0] parent_start;
    logic                 has_parent;
    logic [FieldDepW-1:0] nest_depth;
    logic [FieldOffW-1:0] end_offset;
    logic [FieldOffW-1:0] start_offset;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/markup_tag_nesting_scanner.sv =====
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid_i/tready_o      tdata: byte_value; tuser: doc_start
// m_axis    out  m_axis_tvalid_o/tready_i      tdata: element offsets; tuser: error_code
//
// One byte per cycle while input is ready; each accepted byte's result is
// registered directly. The top two stack entries live in registers, the third is
// prefetched from the stack memory through its registered read port.
// Reset clears modes, offset, tag start and stack pointer at once; the stack
// memory is not cleared and needs no clearing pass.
// A skid register behind the output register keeps input ready while one
// result waits; input stalls only when both hold a result.
`default_nettype none

module markup_tag_nesting_scanner
  import mkts_pkg::*;
#(
  parameter int unsigned STACK_DEPTH  = 32,
  parameter int unsigned OFFSET_WIDTH = 24
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] byte_value
  input  wire logic [0:0]  s_axis_tuser_i,   // [0] doc_start
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [23:0] start_offset, [47:24] end_offset, [53:48] nest_depth,
  // [54] has_parent, [78:55] parent_start, [79] self_closing
  output logic [79:0]      m_axis_tdata_o,
  output logic [1:0]       m_axis_tuser_o    // [1:0] error_code
);

  `include "markup_tag_nesting_scanner_assert.svh"

  localparam int unsigned SpW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned OW  = OFFSET_WIDTH;

  function automatic logic [FieldOffW-1:0] off_field(input logic [OW-1:0] v);
    logic [OW+FieldOffW-1:0] w;
    w = {{FieldOffW{1'b0}}, v};
    return w[FieldOffW-1:0];
  endfunction

  function automatic logic [FieldDepW-1:0] dep_field(input logic [SpW-1:0] v);
    logic [SpW+FieldDepW-1:0] w;
    w = {{FieldDepW{1'b0}}, v};
    return w[FieldDepW-1:0];
  endfunction

  logic [1:0]     mode_q, mode_d, mode_cur;
  logic [1:0]     quote_q, quote_d, quote_cur;
  logic [OW-1:0]  start_q, start_d, start_cur;
  logic [OW-1:0]  offset_q, here;
  logic [SpW-1:0] sp_q, sp_d, sp_cur, sp_nxt, rd_sp;
  logic [OW-1:0]  top_q, sec_q, rd_q;
  logic [OW-1:0]  mem [STACK_DEPTH];

  logic           in_fire, out_fire, doc;
  logic [7:0]     c;
  logic           push, pop, res_valid;
  result_t        res, out_q, skid_q;
  logic           m_valid_q, skid_valid_q;

  assign in_fire  = s_axis_tvalid_i & s_axis_tready_o;
  assign out_fire = m_valid_q & m_axis_tready_i;
  assign doc      = s_axis_tuser_i[0];
  assign c        = s_axis_tdata_i;

  always_comb begin
    mode_cur  = doc ? MODE_CONTENT : mode_q;
    quote_cur = doc ? QUOTE_NONE : quote_q;
    start_cur = doc ? '0 : start_q;
    sp_cur    = doc ? '0 : sp_q;
    here      = doc ? '0 : offset_q;

    mode_d    = mode_cur;
    quote_d   = quote_cur;
    start_d   = start_cur;
    sp_d      = sp_cur;
    push      = 1'b0;
    pop       = 1'b0;
    res_valid = 1'b0;
    res       = '0;

    if (quote_cur != QUOTE_NONE) begin
      if ((quote_cur == QUOTE_DOUBLE && c == CH_DQUOTE) ||
          (quote_cur == QUOTE_SINGLE && c == CH_SQUOTE)) begin
        quote_d = QUOTE_NONE;
      end
    end else begin
      unique case (mode_cur)
        MODE_CONTENT: begin
          if (c == CH_LT) begin
            mode_d  = MODE_TAG_OPENED;
            start_d = here;
          end
        end
        MODE_TAG_OPENED: begin
          priority if (c == CH_SLASH) mode_d = MODE_END_TAG;
          else if (c == CH_QMARK)     mode_d = MODE_CONTENT;
          else                        mode_d = MODE_OPEN_TAG;
        end
        MODE_OPEN_TAG: begin
          priority if (c == CH_SLASH) begin
            res_valid          = 1'b1;
            res.start_offset   = off_field(start_cur);
            res.end_offset     = off_field(here);
            res.nest_depth     = dep_field(sp_cur);
            res.has_parent     = (sp_cur != '0);
            res.parent_start   = (sp_cur != '0) ? off_field(top_q) : '0;
            res.self_closing   = 1'b1;
            res.error_code     = ERR_NONE;
            mode_d             = MODE_CONTENT;
          end else if (c == CH_GT) begin
            if (sp_cur < SpW'(STACK_DEPTH)) begin
              push = 1'b1;
              sp_d = sp_cur + SpW'(1);
            end else begin
              // full stack: report and drop the tag
              res_valid        = 1'b1;
              res.start_offset = off_field(start_cur);
              res.end_offset   = off_field(here);
              res.nest_depth   = dep_field(sp_cur);
              res.has_parent   = 1'b1;
              res.parent_start = off_field(top_q);
              res.error_code   = ERR_OVERFLOW;
            end
            mode_d = MODE_CONTENT;
          end else if (c == CH_DQUOTE) begin
            quote_d = QUOTE_DOUBLE;
          end else if (c == CH_SQUOTE) begin
            quote_d = QUOTE_SINGLE;
          end
        end
        MODE_END_TAG: begin
          priority if (c == CH_GT) begin
            res_valid = 1'b1;
            if (sp_cur == '0) begin
              res.start_offset = off_field(start_cur);
              res.end_offset   = off_field(here);
              res.error_code   = ERR_UNMATCHED;
            end else begin
              pop              = 1'b1;
              sp_d             = sp_cur - SpW'(1);
              res.start_offset = off_field(top_q);
              res.end_offset   = off_field(here);
              res.nest_depth   = dep_field(sp_cur - SpW'(1));
              res.has_parent   = (sp_cur > SpW'(1));
              res.parent_start = (sp_cur > SpW'(1)) ? off_field(sec_q) : '0;
              res.error_code   = ERR_NONE;
            end
            mode_d = MODE_CONTENT;
          end else if (c == CH_DQUOTE) begin
            quote_d = QUOTE_DOUBLE;
          end else if (c == CH_SQUOTE) begin
            quote_d = QUOTE_SINGLE;
          end
        end
      endcase
    end
  end

  // Prefetch the entry below the two cached ones for the coming cycle.
  assign sp_nxt = in_fire ? sp_d : sp_q;
  assign rd_sp  = sp_nxt - SpW'(3);

  always_ff @(posedge clk_i) begin
    if (in_fire && push) begin
      mem[sp_cur[AW-1:0]] <= start_cur;
    end
    rd_q <= mem[rd_sp[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (push) begin
        top_q <= start_cur;
        sec_q <= top_q;
      end else if (pop) begin
        top_q <= sec_q;
        sec_q <= rd_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_CONTENT;
      quote_q  <= QUOTE_NONE;
      start_q  <= '0;
      sp_q     <= '0;
      offset_q <= '0;
    end else if (in_fire) begin
      mode_q   <= mode_d;
      quote_q  <= quote_d;
      start_q  <= start_d;
      sp_q     <= sp_d;
      offset_q <= here + OW'(1);
    end
  end

  // Output register with skid stage
  assign s_axis_tready_o = ~skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q    <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire && res_valid) begin
      if (m_valid_q && !out_fire) begin
        skid_valid_q <= 1'b1;
      end
      m_valid_q <= 1'b1;
    end else if (out_fire) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire && res_valid) begin
      if (m_valid_q && !out_fire) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {out_q.self_closing, out_q.parent_start, out_q.has_parent,
                            out_q.nest_depth, out_q.end_offset, out_q.start_offset};
  assign m_axis_tuser_o  = out_q.error_code;

  `MKTS_ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_q || m_valid_q || !rst_ni,
                      "skid holds a beat while output register is empty")
  `MKTS_ASSERT(a_sp_bound, sp_q <= SpW'(STACK_DEPTH),
               "stack pointer beyond stack depth")
  `MKTS_ASSERT(a_unmatched_flat,
               m_valid_q && out_q.error_code == ERR_UNMATCHED |->
               out_q.nest_depth == '0 && !out_q.has_parent && !out_q.self_closing,
               "unmatched end tag result carries nesting data")
  `MKTS_ASSERT(a_push_advances, in_fire && push |=> (sp_q - $past(sp_cur)) == SpW'(1),
               "push did not advance stack pointer")

endmodule

`default_nettype wire
